// ===== rtl/core/base64_stream_decoder_top_assert.svh =====
// Assertion macros shared by the base64 stream decoder RTL.
`ifndef BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`define BASE64_STREAM_DECODER_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define B64SD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define B64SD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/b64sd_pkg.sv =====
// Types, constants and symbol helpers for the base64 stream decoder.
`timescale 1ns / 1ps

package b64sd_pkg;

    localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] STATUS_COMPLETE = 2'd0;
    localparam logic [1:0] STATUS_PADDED   = 2'd1;
    localparam logic [1:0] STATUS_ERROR    = 2'd2;

    localparam int MAX_RESULTS = 4;
    localparam int FIFO_DEPTH  = 16;

    typedef struct packed {
        logic       bad;
        logic [5:0] val;
    } t_sym;

    // Map one character to its 6-bit symbol value, or flag it as no symbol.
    function automatic t_sym sym_decode(input logic [7:0] c);
        t_sym s;
        s.bad = 1'b0;
        s.val = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            s.val = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            s.val = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            s.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.val = 6'h3E;
        end else if (c == 8'h2F) begin
            s.val = 6'h3F;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

    // Newline, carriage return, space or tab.
    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h0A, 8'h0D, 8'h20, 8'h09};
    endfunction

endpackage

// ===== rtl/core/base64_stream_decoder_top.sv =====
// Base64 stream decoder: one character per transfer in, data bytes and status out.
// A character is held in the input register; its results then enter the queue in order.
// Throughput: one character per cycle in and one result per cycle out, each while its
// ready is high; o_in_ready drops while the 16-entry queue holds more than eight
// results behind a character, twelve without.
// Reset (i_rst_n low at a clock edge) empties the queue and starts a new text at index 0.
`timescale 1ns / 1ps
`include "base64_stream_decoder_top_assert.svh"

module base64_stream_decoder_top #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // character channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_char_in,
    input  logic                      i_last_in,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_kind,
    output logic [7:0]                o_data_byte,
    output logic [1:0]                o_status,
    output logic [POSITION_WIDTH-1:0] o_stop_position,
    output logic                      o_last_result
);

    import b64sd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

    typedef enum logic [1:0] {
        MODE_DECODE,
        MODE_PADDED,
        MODE_ERROR
    } t_mode;

    // ------------------------------------------------------------------
    // Input register: hold the character taken on the last transfer.
    // ------------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       w_in_xfer;

    assign w_in_xfer = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_xfer;
        end
        if (w_in_xfer) begin
            r_char <= i_char_in;
            r_last <= i_last_in;
        end
    end

    // ------------------------------------------------------------------
    // Decoder state. The gathered characters need no reset: only entries
    // written in the current group are ever judged.
    // ------------------------------------------------------------------
    logic [7:0]                r_group_chars [3];
    logic [1:0]                r_group_fill;
    logic [POSITION_WIDTH-1:0] r_char_index;
    logic [POSITION_WIDTH-1:0] r_group_start;
    t_mode                     r_decode_mode;
    logic [POSITION_WIDTH-1:0] r_end_position;
    logic                      r_end_found;

    logic [7:0]                n_group_chars [3];
    logic [1:0]                n_group_fill;
    logic [POSITION_WIDTH-1:0] n_char_index;
    logic [POSITION_WIDTH-1:0] n_group_start;
    t_mode                     n_decode_mode;
    logic [POSITION_WIDTH-1:0] n_end_position;
    logic                      n_end_found;

    // Results of the character in the input register, in delivery order.
    logic                      w_res_kind   [MAX_RESULTS];
    logic [7:0]                w_res_data   [MAX_RESULTS];
    logic [1:0]                w_res_status [MAX_RESULTS];
    logic [POSITION_WIDTH-1:0] w_res_pos    [MAX_RESULTS];
    logic [RES_W-1:0]          w_res_count;

    // Judge the gathered group against the character that completes it.
    t_sym w_s0, w_s1, w_s2, w_s3;
    logic [7:0] w_b0, w_b1, w_b2;

    assign w_s0 = sym_decode(r_group_chars[0]);
    assign w_s1 = sym_decode(r_group_chars[1]);
    assign w_s2 = sym_decode(r_group_chars[2]);
    assign w_s3 = sym_decode(r_char);
    assign w_b0 = {w_s0.val, w_s1.val[5:4]};
    assign w_b1 = {w_s1.val[3:0], w_s2.val[5:2]};
    assign w_b2 = {w_s2.val[1:0], w_s3.val};

    always_comb begin
        logic [RES_W-1:0]          data_cnt;
        logic [1:0]                st;
        logic [POSITION_WIDTH-1:0] stop;

        n_group_chars  = r_group_chars;
        n_group_fill   = r_group_fill;
        n_char_index   = r_char_index;
        n_group_start  = r_group_start;
        n_decode_mode  = r_decode_mode;
        n_end_position = r_end_position;
        n_end_found    = r_end_found;
        data_cnt       = '0;
        st             = STATUS_COMPLETE;
        stop           = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            w_res_kind[k]   = KIND_DATA;
            w_res_data[k]   = 8'd0;
            w_res_status[k] = STATUS_COMPLETE;
            w_res_pos[k]    = '0;
        end
        w_res_count = '0;

        if (r_in_valid) begin
            case (r_decode_mode)
                MODE_DECODE: begin
                    if (r_group_fill == 2'd0 && is_space(r_char)) begin
                        // skip whitespace between groups
                    end else if (r_group_fill != 2'd3) begin
                        if (r_group_fill == 2'd0) begin
                            n_group_start = r_char_index;
                        end
                        n_group_chars[r_group_fill] = r_char;
                        n_group_fill = r_group_fill + 2'd1;
                    end else begin
                        n_group_fill = 2'd0;
                        if (w_s0.bad || w_s1.bad) begin
                            n_decode_mode = MODE_ERROR;
                        end else if (w_s2.bad) begin
                            if (r_group_chars[2] == CHAR_PAD && r_char == CHAR_PAD) begin
                                w_res_data[0] = w_b0;
                                data_cnt      = RES_W'(1);
                                n_decode_mode = MODE_PADDED;
                            end else begin
                                n_decode_mode = MODE_ERROR;
                            end
                        end else if (w_s3.bad) begin
                            if (r_char == CHAR_PAD) begin
                                w_res_data[0] = w_b0;
                                w_res_data[1] = w_b1;
                                data_cnt      = RES_W'(2);
                                n_decode_mode = MODE_PADDED;
                            end else begin
                                n_decode_mode = MODE_ERROR;
                            end
                        end else begin
                            w_res_data[0] = w_b0;
                            w_res_data[1] = w_b1;
                            w_res_data[2] = w_b2;
                            data_cnt      = RES_W'(3);
                        end
                        if (n_decode_mode == MODE_ERROR) begin
                            n_end_position = r_group_start;
                        end
                        if (n_decode_mode == MODE_PADDED) begin
                            n_end_found = 1'b0;
                        end
                    end
                end
                MODE_PADDED: begin
                    // note where the first non-whitespace after padding sits
                    if (!r_end_found && !is_space(r_char)) begin
                        n_end_position = r_char_index;
                        n_end_found    = 1'b1;
                    end
                end
                default: begin
                    // error: ignore everything up to the last character
                end
            endcase

            n_char_index = (r_char_index != POS_MAX) ?
                           r_char_index + POSITION_WIDTH'(1) : POS_MAX;
            w_res_count  = data_cnt;

            if (r_last) begin
                case (n_decode_mode)
                    MODE_ERROR: begin
                        st   = STATUS_ERROR;
                        stop = n_end_position;
                    end
                    MODE_PADDED: begin
                        st   = STATUS_PADDED;
                        stop = n_end_found ? n_end_position : n_char_index;
                    end
                    default: begin
                        st   = STATUS_COMPLETE;
                        stop = (n_group_fill != 2'd0) ? n_group_start : n_char_index;
                    end
                endcase
                w_res_kind[data_cnt[1:0]]   = KIND_STATUS;
                w_res_data[data_cnt[1:0]]   = 8'd0;
                w_res_status[data_cnt[1:0]] = st;
                w_res_pos[data_cnt[1:0]]    = stop;
                w_res_count = data_cnt + RES_W'(1);

                // start a new text
                n_group_fill   = 2'd0;
                n_char_index   = '0;
                n_group_start  = '0;
                n_decode_mode  = MODE_DECODE;
                n_end_position = '0;
                n_end_found    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_fill   <= 2'd0;
            r_char_index   <= '0;
            r_group_start  <= '0;
            r_decode_mode  <= MODE_DECODE;
            r_end_position <= '0;
            r_end_found    <= 1'b0;
        end else begin
            r_group_fill   <= n_group_fill;
            r_char_index   <= n_char_index;
            r_group_start  <= n_group_start;
            r_decode_mode  <= n_decode_mode;
            r_end_position <= n_end_position;
            r_end_found    <= n_end_found;
        end
        r_group_chars <= n_group_chars;
    end

    // ------------------------------------------------------------------
    // Result queue: take up to four results per cycle, hand out one while the reader is ready.
    // ------------------------------------------------------------------
    logic                      r_fifo_kind   [FIFO_DEPTH];
    logic [7:0]                r_fifo_data   [FIFO_DEPTH];
    logic [1:0]                r_fifo_status [FIFO_DEPTH];
    logic [POSITION_WIDTH-1:0] r_fifo_pos    [FIFO_DEPTH];
    logic                      r_fifo_last   [FIFO_DEPTH];
    logic [PTR_W-1:0]          r_wr_ptr;
    logic [PTR_W-1:0]          r_rd_ptr;
    logic [CNT_W-1:0]          r_count;
    logic                      w_pop;
    logic [SUM_W-1:0]          w_reserved;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (RES_W'(k) < w_res_count) begin
                r_fifo_kind[r_wr_ptr + PTR_W'(k)]   <= w_res_kind[k];
                r_fifo_data[r_wr_ptr + PTR_W'(k)]   <= w_res_data[k];
                r_fifo_status[r_wr_ptr + PTR_W'(k)] <= w_res_status[k];
                r_fifo_pos[r_wr_ptr + PTR_W'(k)]    <= w_res_pos[k];
                r_fifo_last[r_wr_ptr + PTR_W'(k)]   <= (RES_W'(k) == w_res_count - RES_W'(1));
            end
        end
    end

    assign w_pop = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(w_res_count);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(w_res_count) - CNT_W'(w_pop);
        end
    end

    // Take a character only while the queue has room for its results and for
    // those of the character still in the input register.
    assign w_reserved = SUM_W'(r_count) + (r_in_valid ? SUM_W'(MAX_RESULTS) : '0);
    assign o_in_ready = (w_reserved <= SUM_W'(FIFO_DEPTH - MAX_RESULTS));

    assign o_out_valid     = (r_count != '0);
    assign o_kind          = r_fifo_kind[r_rd_ptr];
    assign o_data_byte     = r_fifo_data[r_rd_ptr];
    assign o_status        = r_fifo_status[r_rd_ptr];
    assign o_stop_position = r_fifo_pos[r_rd_ptr];
    assign o_last_result   = r_fifo_last[r_rd_ptr];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `B64SD_ASSERT_ALWAYS(a_queue_bound, r_count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `B64SD_ASSERT_IMPLY(a_ended_empty, r_decode_mode != MODE_DECODE, r_group_fill == '0, "open group")
    `B64SD_ASSERT_IMPLY(a_found_padded, r_end_found, r_decode_mode == MODE_PADDED, "stray end mark")
    `B64SD_ASSERT_IMPLY(a_status_last, o_out_valid && o_kind, o_last_result, "status not last")

endmodule
